>>> src/nesr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and reset values for the note event slot router.
package nesr_pkg;

   localparam int NUM_REGS  = 8;
   localparam int NOTE_W    = 7;
   localparam int KIND_W    = 2;
   localparam int ID_W      = 64;
   localparam int PAYLOAD_W = 32;
   localparam int SLOT_W    = 3;
   localparam int REG_IDX_W = 3;

   localparam int TABLE_DEPTH_DEF   = 64;
   localparam int SLOT_COUNT_DEF    = 8;
   localparam int SLOT_CAPACITY_DEF = 256;

   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;

   localparam logic [NOTE_W-1:0] NOTE_RESET [NUM_REGS] =
      '{7'd36, 7'd38, 7'd42, 7'd46, 7'd39, 7'd45, 7'd37, 7'd40};

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_EMIT
   } state_type;

endpackage

>>> src/note_event_slot_router_unit.sv
`timescale 1ns / 1ps
// Note event slot router: id table in one synchronous memory, per-slot fill counters.
//
//  channel | direction | handshake           | contents
//  req     | in        | req_valid/req_ready | buffer_start, event_kind, event_id, note, payload
//  rsp     | out       | rsp_valid/rsp_ready | slot, kind, id, note, payload
//  csr     | in        | csr_we              | csr_index selects slotN_note, csr_wdata
//
// One item at a time. An item with a zero id, or a note-on matching no slot, is dropped.
// Otherwise it passes the idle, search, decide and emit steps; the search is skipped on an empty
// table and ends on a hit or after the last entry. A note-off found in the table also moves
// the last entry into its place; an item other than a note-on whose id is not found ends
// after the decide step. The table memory's single read port searches one entry per cycle.
// Reset clears the entry count and fill counters; the table memory needs no clearing.
// A result waiting in the output register holds the block in its emit step.
module note_event_slot_router_unit
   import nesr_pkg::*;
#(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
   parameter int SLOT_CAPACITY = SLOT_CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_buffer_start,
   input  logic [KIND_W-1:0]    req_event_kind,
   input  logic [ID_W-1:0]      req_event_id,
   input  logic [NOTE_W-1:0]    req_note_value,
   input  logic [PAYLOAD_W-1:0] req_payload,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [KIND_W-1:0]    rsp_out_kind,
   output logic [ID_W-1:0]      rsp_out_id,
   output logic [NOTE_W-1:0]    rsp_out_note,
   output logic [PAYLOAD_W-1:0] rsp_out_payload,

   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [NOTE_W-1:0]    csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int FW = $clog2(SLOT_CAPACITY + 1);

   // configuration
   logic [NOTE_W-1:0] note_ff [NUM_REGS];

   // control
   state_type state_ff, state_in;

   // latched item
   logic                 kind_is_on_ff, kind_is_on_in;
   logic                 kind_is_off_ff, kind_is_off_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [NOTE_W-1:0]    nval_ff, nval_in;
   logic [PAYLOAD_W-1:0] pay_ff, pay_in;
   logic [SLOT_W-1:0]    match_slot_ff, match_slot_in;

   // search
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     found_idx_ff, found_idx_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;
   logic [SLOT_W-1:0] emit_slot_ff, emit_slot_in;

   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic [FW-1:0] fill_ff [SLOT_COUNT];
   logic [FW-1:0] fill_in [SLOT_COUNT];

   // table memory
   entry_type     mem [TABLE_DEPTH];
   entry_type     rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [NOTE_W-1:0]    rsp_note_ff, rsp_note_in;
   logic [PAYLOAD_W-1:0] rsp_pay_ff, rsp_pay_in;

   logic              accept;
   logic              match_vld_c;
   logic [SLOT_W-1:0] match_slot_c;
   logic              hit;
   logic              scan_done;
   logic              out_free;
   logic              load_out;

   assign accept    = req_valid && req_ready;
   assign hit       = cmp_vld_ff && (rd_data_ff.id == id_ff);
   assign scan_done = !cmp_vld_ff && (scan_idx_ff == entry_count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lowest-numbered slot whose note matches wins
   always_comb begin
      match_vld_c  = 1'b0;
      match_slot_c = '0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (note_ff[s] == req_note_value) begin
            match_vld_c  = 1'b1;
            match_slot_c = SLOT_W'(s);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_event_id == '0) begin
                  state_in = ST_IDLE;
               end else if ((req_event_kind == KIND_NOTE_ON) && !match_vld_c) begin
                  state_in = ST_IDLE;
               end else if (entry_count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit || scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!kind_is_on_ff && !found_ff) begin
               state_in = ST_IDLE;
            end else if (kind_is_off_ff) begin
               state_in = ST_MOVE_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      kind_is_on_in  = kind_is_on_ff;
      kind_is_off_in = kind_is_off_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      nval_in        = nval_ff;
      pay_in         = pay_ff;
      match_slot_in  = match_slot_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_slot_in  = found_slot_ff;
      emit_slot_in   = emit_slot_ff;
      entry_count_in = entry_count_ff;
      fill_in        = fill_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      mem_we         = 1'b0;
      mem_waddr      = found_idx_ff;
      mem_wdata      = rd_data_ff;
      load_out       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_is_on_in  = (req_event_kind == KIND_NOTE_ON);
               kind_is_off_in = (req_event_kind == KIND_NOTE_OFF);
               kind_in        = req_event_kind;
               id_in          = req_event_id;
               nval_in        = req_note_value;
               pay_in         = req_payload;
               match_slot_in  = match_slot_c;
               scan_idx_in    = '0;
               found_in       = 1'b0;
               if (req_buffer_start) begin
                  for (int s = 0; s < SLOT_COUNT; s++) begin
                     fill_in[s] = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            // read of entry n overlaps the compare of entry n-1
            if (!hit && (scan_idx_ff < entry_count_ff)) begin
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff[AW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[AW-1:0];
            end
            if (hit) begin
               found_in      = 1'b1;
               found_idx_in  = cmp_idx_ff;
               found_slot_in = rd_data_ff.slot;
            end
         end
         ST_DECIDE: begin
            if (kind_is_on_ff) begin
               emit_slot_in   = match_slot_ff;
               mem_wdata.id   = id_ff;
               mem_wdata.slot = match_slot_ff;
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = found_idx_ff;
               end else if (entry_count_ff < CW'(TABLE_DEPTH)) begin
                  mem_we         = 1'b1;
                  mem_waddr      = entry_count_ff[AW-1:0];
                  entry_count_in = entry_count_ff + CW'(1);
               end
            end else begin
               emit_slot_in = found_slot_ff;
               if (kind_is_off_ff && found_ff) begin
                  entry_count_in = entry_count_ff - CW'(1);
               end
            end
         end
         ST_MOVE_RD: begin
            // last entry, count already decremented
            rd_en   = 1'b1;
            rd_addr = entry_count_ff[AW-1:0];
         end
         ST_MOVE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = found_idx_ff;
            mem_wdata = rd_data_ff;
         end
         ST_EMIT: begin
            if (out_free && (fill_ff[emit_slot_ff[SW-1:0]] < FW'(SLOT_CAPACITY))) begin
               load_out = 1'b1;
               fill_in[emit_slot_ff[SW-1:0]] = fill_ff[emit_slot_ff[SW-1:0]] + FW'(1);
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_pay_in   = rsp_pay_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = emit_slot_ff;
         rsp_kind_in  = kind_ff;
         rsp_id_in    = id_ff;
         rsp_note_in  = nval_ff;
         rsp_pay_in   = pay_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cmp_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            fill_ff[s] <= '0;
         end
         for (int r = 0; r < NUM_REGS; r++) begin
            note_ff[r] <= NOTE_RESET[r];
         end
      end else begin
         state_ff       <= state_in;
         cmp_vld_ff     <= cmp_vld_in;
         found_ff       <= found_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         fill_ff        <= fill_in;
         if (csr_we) begin
            note_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_is_on_ff  <= kind_is_on_in;
      kind_is_off_ff <= kind_is_off_in;
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      nval_ff        <= nval_in;
      pay_ff         <= pay_in;
      match_slot_ff  <= match_slot_in;
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_idx_ff   <= found_idx_in;
      found_slot_ff  <= found_slot_in;
      emit_slot_ff   <= emit_slot_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_note_ff    <= rsp_note_in;
      rsp_pay_ff     <= rsp_pay_in;
   end

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_note    = rsp_note_ff;
   assign rsp_out_payload = rsp_pay_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(entry_count_ff)) |->
         (entry_count_ff == $past(entry_count_ff) + CW'(1) ||
          entry_count_ff == $past(entry_count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (rd_en && state_ff == ST_SCAN) |-> (scan_idx_ff < entry_count_ff))
      else $error("search read past last valid entry");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (state_ff == ST_EMIT && out_free))
      else $error("result loaded over a pending transfer");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (fill_ff[$past(emit_slot_ff[SW-1:0])] <= FW'(SLOT_CAPACITY)))
      else $error("slot fill above capacity");

endmodule
